/* rtl/core/bnms_pkg.sv */
// ----------------------------------------------------------------------------
// bnms_pkg
// types, constants and tables shared by the box suppression block
// ----------------------------------------------------------------------------
`default_nettype none

package bnms_pkg;

   localparam int MaxBoxes  = 1024;
   localparam int MaxPicked = 64;
   localparam int BoxAw     = $clog2(MaxBoxes);
   localparam int PickAw    = $clog2(MaxPicked);

   // register indexes of the csr channel
   localparam logic [1:0] CSR_MAX_OUTPUTS     = 2'd0;
   localparam logic [1:0] CSR_IOU_THRESHOLD   = 2'd1;
   localparam logic [1:0] CSR_SCORE_FLOOR     = 2'd2;
   localparam logic [1:0] CSR_SOFT_SIGMA      = 2'd3;

   localparam logic [15:0] LOG2E_Q15 = 16'd47274;

   typedef enum logic [4:0] {
      ST_LOAD, ST_SEL, ST_SCAN_RD, ST_SCAN_CMP, ST_SWAP_A, ST_SWAP_B,
      ST_TGT_RD, ST_TGT_WAIT, ST_CHK, ST_PK_RD, ST_PK_WAIT, ST_GEOM,
      ST_MUL_AA, ST_MUL_AB, ST_MUL_IN, ST_UNION, ST_DIV_IOU, ST_IOU_CHK,
      ST_MUL_SQ, ST_DIV_ARG, ST_MUL_T, ST_MUL_FRAC, ST_MUL_S, ST_WRBACK,
      ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic signed [15:0] x2;
      logic signed [15:0] y2;
      logic signed [15:0] x1;
      logic signed [15:0] y1;
   } box_type;

   typedef struct packed {
      logic [6:0]         chk;
      logic signed [15:0] score;
      logic [BoxAw-1:0]   idx;
   } cand_type;

   typedef struct packed {
      logic signed [15:0] score;
      logic [BoxAw-1:0]   idx;
   } pick_type;

   // divider control and status
   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

   // 2^(-k/16) in Q1.16
   function automatic logic [16:0] pow2_frac(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd62757;
         5'd2:    v = 17'd60097;
         5'd3:    v = 17'd57549;
         5'd4:    v = 17'd55109;
         5'd5:    v = 17'd52773;
         5'd6:    v = 17'd50535;
         5'd7:    v = 17'd48393;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd44376;
         5'd10:   v = 17'd42495;
         5'd11:   v = 17'd40693;
         5'd12:   v = 17'd38968;
         5'd13:   v = 17'd37316;
         5'd14:   v = 17'd35734;
         5'd15:   v = 17'd34219;
         5'd16:   v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/bnms_if.sv */
// ----------------------------------------------------------------------------
// bnms channel interfaces
// valid/ready channels for boxes, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface bnms_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] corner_y1;
   logic signed [15:0] corner_x1;
   logic signed [15:0] corner_y2;
   logic signed [15:0] corner_x2;
   logic signed [15:0] box_score;
   logic               last_box;
   modport source (output valid, corner_y1, corner_x1, corner_y2, corner_x2,
                   box_score, last_box, input ready);
   modport sink (input valid, corner_y1, corner_x1, corner_y2, corner_x2,
                 box_score, last_box, output ready);
endinterface

interface bnms_rsp_if;
   logic               valid;
   logic               ready;
   logic [9:0]         picked_index;
   logic signed [15:0] picked_score;
   logic               entry_valid;
   logic [6:0]         picked_count;
   logic               last_entry;
   modport source (output valid, picked_index, picked_score, entry_valid,
                   picked_count, last_entry, input ready);
   modport sink (input valid, picked_index, picked_score, entry_valid,
                 picked_count, last_entry, output ready);
endinterface

interface bnms_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bnms_div.sv */
// ----------------------------------------------------------------------------
// bnms_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bnms_div
   import bnms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_ctl_type ctl_in,
   input  wire logic [47:0] dividend,
   input  wire logic [33:0] divisor,
   output div_ctl_type      ctl_out,
   output logic [47:0]      quotient
);

   logic [33:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [33:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[47]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl_in.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? 34'(rem_sh - {1'b0, dsr_ff}) : rem_sh[33:0];
         quo_in = {quo_ff[46:0], ge};
         cnt_in = 6'(cnt_ff + 6'd1);
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      ctl_out.start = busy_ff;
      ctl_out.done  = done_ff;
      quotient      = quo_ff;
   end

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctl_in.start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");

endmodule

`default_nettype wire

/* rtl/core/box_non_max_suppression_unit.sv */
// ----------------------------------------------------------------------------
// box_non_max_suppression_unit
// non-maximum suppression over a set of boxes with optional gaussian decay
// ----------------------------------------------------------------------------
// Boxes stream in on req_chan, one transaction per cycle while loading, into a
// 1024-entry box memory; boxes with a score above the score floor register
// also go to a candidate memory. The box flagged last_box starts selection and
// req_chan drops ready until the run's results are out. Selection finds the
// best candidate with a scan that reads and compares each remaining one,
// then checks it against each picked box not yet checked against it, newest
// first: the IoU uses one shared multiplier, then a 48-step bit-serial divider
// that holds the sequencer (skipped when either box has zero area), and a
// second pass through the same divider follows when soft_sigma is nonzero.
// Results then leave on rsp_chan, exactly max_outputs entries (clamped to
// 1..64), each held until the sink takes it. No clearing pass is needed:
// every memory entry whose value a run uses was written in that run.
// ----------------------------------------------------------------------------
`default_nettype none

module box_non_max_suppression_unit
   import bnms_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bnms_req_if.sink   req_chan,
   bnms_rsp_if.source rsp_chan,
   bnms_csr_if.sink   csr_chan
);

   // configuration registers
   logic [6:0]         max_out_ff;
   logic [15:0]        iou_thr_ff;
   logic signed [15:0] score_thr_ff;
   logic [15:0]        sigma_ff;

   state_type state_ff, state_in;

   // memories
   box_type  box_mem  [MaxBoxes];
   cand_type cand_mem [MaxBoxes];
   pick_type pick_mem [MaxPicked];
   box_type  box_rd_q;
   cand_type cand_rd_q;
   pick_type pick_rd_q;

   logic             box_we, box_re;
   logic [BoxAw-1:0] box_wa, box_ra;
   box_type          box_wd;
   logic             cand_we;
   logic [BoxAw-1:0] cand_wa, cand_ra;
   cand_type         cand_wd;
   logic              pick_we;
   logic [PickAw-1:0] pick_wa, pick_ra;
   pick_type          pick_wd;

   // run counters
   logic [BoxAw:0] box_cnt_ff, box_cnt_in;
   logic [BoxAw:0] cand_cnt_ff, cand_cnt_in;
   logic [BoxAw:0] start_ff, start_in;
   logic [BoxAw:0] scan_ff, scan_in;
   logic [6:0]     len_ff, len_in;
   logic [6:0]     pick_i_ff, pick_i_in;
   logic [6:0]     emit_k_ff, emit_k_in;

   // current candidate
   cand_type           best_ff, best_in;
   cand_type           first_ff, first_in;
   logic [BoxAw:0]     best_pos_ff, best_pos_in;
   logic signed [15:0] orig_ff, orig_in;
   logic signed [15:0] s_ff, s_in;
   logic               hard_ff, hard_in;
   box_type            tgt_ff, tgt_in;

   // overlap math
   logic [15:0] ah_ff, aw_ff, bh_ff, bw_ff, iy_ff, ix_ff;
   logic [15:0] ah_in, aw_in, bh_in, bw_in, iy_in, ix_in;
   logic        zero_ff, zero_in;
   logic [31:0] aa_ff, aa_in, bb_ff, bb_in, inter_ff, inter_in;
   logic [15:0] iou_ff, iou_in;
   logic [19:0] arg_ff, arg_in;
   logic [20:0] t_ff, t_in;
   logic [16:0] w_ff, w_in;

   // results
   logic [9:0]         o_idx_ff, o_idx_in;
   logic signed [15:0] o_score_ff, o_score_in;
   logic               o_valid_ff, o_valid_in;
   logic [6:0]         o_count_ff, o_count_in;
   logic               o_last_ff, o_last_in;

   // shared multiplier
   logic [19:0] mul_a;
   logic [16:0] mul_b;
   logic [36:0] mul_p;

   div_ctl_type div_ctl_in, div_ctl_out;
   logic [47:0] div_dividend, div_q;
   logic [33:0] div_divisor;

   // derived values
   logic [6:0]     m_clamp;
   logic [BoxAw:0] limit;
   logic           req_take, rsp_take;

   // geometry helpers
   logic signed [15:0] aylo, ayhi, axlo, axhi, bylo, byhi, bxlo, bxhi;
   logic signed [16:0] iy_s, ix_s;
   logic [4:0]         frac_k;
   logic [16:0]        pf_lo, pf_hi, v_frac;
   logic [8:0]         t_n;
   logic [15:0]        s_mag;
   logic [20:0]        s_scaled;
   logic signed [15:0] s_new;
   logic [32:0]        uni;

   bnms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (div_ctl_in),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .ctl_out  (div_ctl_out),
      .quotient (div_q)
   );

   // register writes, taken whenever offered
   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff   <= 7'd64;
         iou_thr_ff   <= 16'd16384;
         score_thr_ff <= 16'sh8000;
         sigma_ff     <= 16'd0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MAX_OUTPUTS:     max_out_ff   <= csr_chan.data[6:0];
            CSR_IOU_THRESHOLD:   iou_thr_ff   <= csr_chan.data;
            CSR_SCORE_FLOOR:     score_thr_ff <= csr_chan.data;
            CSR_SOFT_SIGMA:      sigma_ff     <= csr_chan.data;
            default:             ;
         endcase
      end
   end
   assign csr_chan.ready = 1'b1;

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (box_we) box_mem[box_wa] <= box_wd;
      if (box_re) box_rd_q <= box_mem[box_ra];
   end
   always_ff @(posedge clock) begin
      if (cand_we) cand_mem[cand_wa] <= cand_wd;
      cand_rd_q <= cand_mem[cand_ra];
   end
   always_ff @(posedge clock) begin
      if (pick_we) pick_mem[pick_wa] <= pick_wd;
      pick_rd_q <= pick_mem[pick_ra];
   end

   always_comb begin
      if (max_out_ff == 7'd0)                     m_clamp = 7'd1;
      else if (max_out_ff > 7'(MaxPicked))       m_clamp = 7'(MaxPicked);
      else                                        m_clamp = max_out_ff;
      limit    = (cand_cnt_ff < (BoxAw+1)'(m_clamp)) ? cand_cnt_ff : (BoxAw+1)'(m_clamp);
      req_take = req_chan.valid && req_chan.ready;
      rsp_take = rsp_chan.valid && rsp_chan.ready;
   end

   // corner ordering of the target and the picked box
   always_comb begin
      aylo = (tgt_ff.y1 < tgt_ff.y2) ? tgt_ff.y1 : tgt_ff.y2;
      ayhi = (tgt_ff.y1 < tgt_ff.y2) ? tgt_ff.y2 : tgt_ff.y1;
      axlo = (tgt_ff.x1 < tgt_ff.x2) ? tgt_ff.x1 : tgt_ff.x2;
      axhi = (tgt_ff.x1 < tgt_ff.x2) ? tgt_ff.x2 : tgt_ff.x1;
      bylo = (box_rd_q.y1 < box_rd_q.y2) ? box_rd_q.y1 : box_rd_q.y2;
      byhi = (box_rd_q.y1 < box_rd_q.y2) ? box_rd_q.y2 : box_rd_q.y1;
      bxlo = (box_rd_q.x1 < box_rd_q.x2) ? box_rd_q.x1 : box_rd_q.x2;
      bxhi = (box_rd_q.x1 < box_rd_q.x2) ? box_rd_q.x2 : box_rd_q.x1;
      iy_s = 17'((ayhi < byhi) ? ayhi : byhi) - 17'((aylo > bylo) ? aylo : bylo);
      ix_s = 17'((axhi < bxhi) ? axhi : bxhi) - 17'((axlo > bxlo) ? axlo : bxlo);
   end

   // weight and score helpers
   always_comb begin
      frac_k   = {1'b0, t_ff[11:8]};
      pf_lo    = pow2_frac(frac_k);
      pf_hi    = pow2_frac(5'(frac_k + 5'd1));
      v_frac   = 17'(pf_lo - 17'(mul_p[36:8]));
      t_n      = t_ff[20:12];
      s_mag    = s_ff[15] ? 16'(-s_ff) : s_ff;
      s_scaled = mul_p[36:16];
      s_new    = s_ff[15] ? 16'(-s_scaled[15:0]) : s_scaled[15:0];
      uni      = 33'(33'(aa_ff) + 33'(bb_ff) - 33'(inter_ff));
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_AA:   begin mul_a = 20'(ah_ff);  mul_b = 17'(aw_ff); end
         ST_MUL_AB:   begin mul_a = 20'(bh_ff);  mul_b = 17'(bw_ff); end
         ST_MUL_IN:   begin mul_a = 20'(iy_ff);  mul_b = 17'(ix_ff); end
         ST_MUL_SQ:   begin mul_a = 20'(iou_ff); mul_b = 17'(iou_ff); end
         ST_MUL_T:    begin mul_a = arg_ff;      mul_b = 17'(LOG2E_Q15); end
         ST_MUL_FRAC: begin mul_a = 20'(17'(pf_lo - pf_hi)); mul_b = 17'(t_ff[7:0]); end
         ST_MUL_S:    begin mul_a = 20'(s_mag);  mul_b = w_ff; end
         default:     ;
      endcase
      mul_p = 37'(mul_a) * 37'(mul_b);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      box_cnt_in  = box_cnt_ff;
      cand_cnt_in = cand_cnt_ff;
      start_in    = start_ff;
      scan_in     = scan_ff;
      len_in      = len_ff;
      pick_i_in   = pick_i_ff;
      emit_k_in   = emit_k_ff;
      best_in     = best_ff;
      first_in    = first_ff;
      best_pos_in = best_pos_ff;
      orig_in     = orig_ff;
      s_in        = s_ff;
      hard_in     = hard_ff;
      tgt_in      = tgt_ff;
      ah_in = ah_ff; aw_in = aw_ff; bh_in = bh_ff; bw_in = bw_ff;
      iy_in = iy_ff; ix_in = ix_ff; zero_in = zero_ff;
      aa_in = aa_ff; bb_in = bb_ff; inter_in = inter_ff;
      iou_in = iou_ff; arg_in = arg_ff; t_in = t_ff; w_in = w_ff;
      o_idx_in = o_idx_ff; o_score_in = o_score_ff; o_valid_in = o_valid_ff;
      o_count_in = o_count_ff; o_last_in = o_last_ff;

      box_we  = 1'b0;  box_wa = box_cnt_ff[BoxAw-1:0];
      box_wd  = '{x2: req_chan.corner_x2, y2: req_chan.corner_y2,
                  x1: req_chan.corner_x1, y1: req_chan.corner_y1};
      box_re  = 1'b0;  box_ra = pick_rd_q.idx;
      cand_we = 1'b0;  cand_wa = cand_cnt_ff[BoxAw-1:0];
      cand_wd = '{chk: 7'd0, score: req_chan.box_score, idx: box_cnt_ff[BoxAw-1:0]};
      cand_ra = scan_ff[BoxAw-1:0];
      pick_we = 1'b0;  pick_wa = len_ff[PickAw-1:0];
      pick_wd = '{score: s_ff, idx: best_ff.idx};
      pick_ra = emit_k_ff[PickAw-1:0];

      div_ctl_in.start = 1'b0;
      div_ctl_in.done  = 1'b0;
      div_dividend     = {1'b0, inter_ff, 15'd0};
      div_divisor      = 34'(uni);

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (box_cnt_ff < (BoxAw+1)'(MaxBoxes)) begin
                  box_we     = 1'b1;
                  box_cnt_in = (BoxAw+1)'(box_cnt_ff + 1'b1);
                  if (req_chan.box_score > score_thr_ff) begin
                     cand_we     = 1'b1;
                     cand_cnt_in = (BoxAw+1)'(cand_cnt_ff + 1'b1);
                  end
               end
               if (req_chan.last_box) begin
                  start_in = '0;
                  len_in   = '0;
                  state_in = ST_SEL;
               end
            end
         end
         ST_SEL: begin
            if ((BoxAw+1)'(len_ff) < limit && start_ff < cand_cnt_ff) begin
               scan_in  = start_ff;
               state_in = ST_SCAN_RD;
            end else begin
               emit_k_in = '0;
               state_in  = ST_EMIT_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            // ties keep the earlier pool position
            if (scan_ff == start_ff) begin
               best_in     = cand_rd_q;
               first_in    = cand_rd_q;
               best_pos_in = start_ff;
            end else if (best_ff.score < cand_rd_q.score) begin
               best_in     = cand_rd_q;
               best_pos_in = scan_ff;
            end
            scan_in = (BoxAw+1)'(scan_ff + 1'b1);
            if ((BoxAw+1)'(scan_ff + 1'b1) < cand_cnt_ff) state_in = ST_SCAN_RD;
            else                                         state_in = ST_SWAP_A;
         end
         ST_SWAP_A: begin
            cand_we  = 1'b1;
            cand_wa  = best_pos_ff[BoxAw-1:0];
            cand_wd  = first_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            cand_we   = 1'b1;
            cand_wa   = start_ff[BoxAw-1:0];
            cand_wd   = best_ff;
            orig_in   = best_ff.score;
            s_in      = best_ff.score;
            hard_in   = 1'b0;
            pick_i_in = len_ff;
            state_in  = ST_TGT_RD;
         end
         ST_TGT_RD: begin
            box_re   = 1'b1;
            box_ra   = best_ff.idx;
            state_in = ST_TGT_WAIT;
         end
         ST_TGT_WAIT: begin
            tgt_in   = box_rd_q;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (pick_i_ff > best_ff.chk) state_in = ST_PK_RD;
            else                         state_in = ST_WRBACK;
         end
         ST_PK_RD: begin
            pick_ra  = 6'(pick_i_ff - 7'd1);
            state_in = ST_PK_WAIT;
         end
         ST_PK_WAIT: begin
            box_re   = 1'b1;
            state_in = ST_GEOM;
         end
         ST_GEOM: begin
            ah_in   = 16'(ayhi - aylo);
            aw_in   = 16'(axhi - axlo);
            bh_in   = 16'(byhi - bylo);
            bw_in   = 16'(bxhi - bxlo);
            iy_in   = (iy_s > 17'sd0) ? iy_s[15:0] : 16'd0;
            ix_in   = (ix_s > 17'sd0) ? ix_s[15:0] : 16'd0;
            zero_in = (ayhi == aylo) || (axhi == axlo) || (byhi == bylo) || (bxhi == bxlo);
            state_in = ST_MUL_AA;
         end
         ST_MUL_AA: begin aa_in = mul_p[31:0];    state_in = ST_MUL_AB; end
         ST_MUL_AB: begin bb_in = mul_p[31:0];    state_in = ST_MUL_IN; end
         ST_MUL_IN: begin inter_in = mul_p[31:0]; state_in = ST_UNION; end
         ST_UNION: begin
            if (zero_ff) begin
               iou_in   = '0;
               state_in = ST_IOU_CHK;
            end else begin
               div_ctl_in.start = 1'b1;
               state_in         = ST_DIV_IOU;
            end
         end
         ST_DIV_IOU: begin
            if (div_ctl_out.done) begin
               iou_in   = div_q[15:0];
               state_in = ST_IOU_CHK;
            end
         end
         ST_IOU_CHK: begin
            if (iou_ff >= iou_thr_ff) begin
               hard_in  = 1'b1;
               state_in = ST_WRBACK;
            end else if (sigma_ff != 16'd0) begin
               state_in = ST_MUL_SQ;
            end else begin
               pick_i_in = 7'(pick_i_ff - 7'd1);
               state_in  = ST_CHK;
            end
         end
         ST_MUL_SQ: begin
            div_ctl_in.start = 1'b1;
            div_dividend     = 48'(mul_p[31:0]);
            div_divisor      = 34'({sigma_ff, 11'd0});
            state_in         = ST_DIV_ARG;
         end
         ST_DIV_ARG: begin
            div_dividend = 48'(mul_p[31:0]);
            div_divisor  = 34'({sigma_ff, 11'd0});
            if (div_ctl_out.done) begin
               arg_in   = div_q[19:0];
               state_in = ST_MUL_T;
            end
         end
         ST_MUL_T: begin t_in = mul_p[35:15]; state_in = ST_MUL_FRAC; end
         ST_MUL_FRAC: begin
            w_in     = (t_n >= 9'd32) ? 17'd0 : (v_frac >> t_n[4:0]);
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            s_in = s_new;
            if (s_new <= score_thr_ff) begin
               state_in = ST_WRBACK;
            end else begin
               pick_i_in = 7'(pick_i_ff - 7'd1);
               state_in  = ST_CHK;
            end
         end
         ST_WRBACK: begin
            cand_we = 1'b1;
            cand_wa = start_ff[BoxAw-1:0];
            cand_wd = '{chk: len_ff, score: s_ff, idx: best_ff.idx};
            if (!hard_ff && s_ff == orig_ff) begin
               pick_we = 1'b1;
               len_in  = 7'(len_ff + 7'd1);
            end
            // a decayed survivor stays at the front of the pool
            if (!(!hard_ff && s_ff != orig_ff && s_ff > score_thr_ff))
               start_in = (BoxAw+1)'(start_ff + 1'b1);
            state_in = ST_SEL;
         end
         ST_EMIT_RD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (emit_k_ff < len_ff) begin
               o_idx_in   = pick_rd_q.idx;
               o_score_in = pick_rd_q.score;
               o_valid_in = 1'b1;
            end else begin
               o_idx_in   = '0;
               o_score_in = '0;
               o_valid_in = 1'b0;
            end
            o_count_in = len_ff;
            o_last_in  = (7'(emit_k_ff + 7'd1) == m_clamp);
            state_in   = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_take) begin
               if (o_last_ff) begin
                  box_cnt_in  = '0;
                  cand_cnt_in = '0;
                  state_in    = ST_LOAD;
               end else begin
                  emit_k_in = 7'(emit_k_ff + 7'd1);
                  state_in  = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         box_cnt_ff  <= '0;
         cand_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         box_cnt_ff  <= box_cnt_in;
         cand_cnt_ff <= cand_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;   scan_ff <= scan_in;     len_ff <= len_in;
      pick_i_ff <= pick_i_in; emit_k_ff <= emit_k_in;
      best_ff <= best_in;     first_ff <= first_in;   best_pos_ff <= best_pos_in;
      orig_ff <= orig_in;     s_ff <= s_in;           hard_ff <= hard_in;
      tgt_ff <= tgt_in;
      ah_ff <= ah_in; aw_ff <= aw_in; bh_ff <= bh_in; bw_ff <= bw_in;
      iy_ff <= iy_in; ix_ff <= ix_in; zero_ff <= zero_in;
      aa_ff <= aa_in; bb_ff <= bb_in; inter_ff <= inter_in;
      iou_ff <= iou_in; arg_ff <= arg_in; t_ff <= t_in; w_ff <= w_in;
      o_idx_ff <= o_idx_in; o_score_ff <= o_score_in; o_valid_ff <= o_valid_in;
      o_count_ff <= o_count_in; o_last_ff <= o_last_in;
   end

   assign req_chan.ready        = (state_ff == ST_LOAD);
   assign rsp_chan.valid        = (state_ff == ST_EMIT_OUT);
   assign rsp_chan.picked_index = o_idx_ff;
   assign rsp_chan.picked_score = o_score_ff;
   assign rsp_chan.entry_valid  = o_valid_ff;
   assign rsp_chan.picked_count = o_count_ff;
   assign rsp_chan.last_entry   = o_last_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid)) else $error("load and emit overlap");
   a_pick_room: assert property (@(posedge clock) disable iff (reset)
      pick_we |-> (len_ff < m_clamp)) else $error("picked list overflow");
   a_cand_bound: assert property (@(posedge clock) disable iff (reset)
      cand_cnt_ff <= box_cnt_ff) else $error("more candidates than boxes");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && o_last_ff) |=> (box_cnt_ff == '0 && req_chan.ready))
      else $error("run end did not clear counts");

endmodule

`default_nettype wire

/* tb/box_non_max_suppression_unit_tb.sv */
// ----------------------------------------------------------------------------
// box_non_max_suppression_unit_tb
// self-checking bench for the box suppression block
// ----------------------------------------------------------------------------
// Box sets are streamed into req_chan with bursty timing. Each accepted box
// also goes into a predictor inside the bench, which repeats the selection
// (hard IoU suppression, optional gaussian decay) and queues the expected
// result entries. A checker compares every rsp_chan transaction with the
// oldest queued entry. Register writes happen only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_non_max_suppression_unit_tb
   import bnms_pkg::*;
();

   localparam int CycleLimit = 2000000;

   typedef struct {
      logic [9:0]         idx;
      logic signed [15:0] score;
      logic               ev;
      logic [6:0]         cnt;
      logic               le;
   } pick_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bnms_req_if req_bus ();
   bnms_rsp_if rsp_bus ();
   bnms_csr_if csr_bus ();

   box_non_max_suppression_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // expected entries, oldest first
   pick_entry_type expected_picks[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // predictor copy of the block state
   logic [63:0] box_mem [MaxBoxes];
   int          cand_idx [MaxBoxes];
   int          cand_scr [MaxBoxes];
   int          cand_from [MaxBoxes];
   int          pick_idx [MaxPicked];
   int          pick_scr [MaxPicked];
   int          n_boxes = 0;
   int          n_cands = 0;

   // predictor copy of the registers
   int cfg_max_out   = 64;
   int cfg_iou_thr   = 16384;
   int cfg_score_thr = -32768;
   int cfg_sigma     = 0;

   // 2^(-k/16) in Q1.16
   const longint unsigned frac_tab [17] = '{
      65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
      44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

   // ------------------------------------------------------------------
   // arithmetic of the selection pass
   // ------------------------------------------------------------------
   function automatic int sx(logic [15:0] v);
      return int'(signed'(v));
   endfunction

   function automatic int overlap_q15(int a, int b);
      logic [63:0] ba, bb;
      int aylo, ayhi, axlo, axhi, bylo, byhi, bxlo, bxhi, iy, ix;
      longint area_a, area_b, inter, uni;
      ba = box_mem[a];
      bb = box_mem[b];
      aylo = (sx(ba[15:0]) < sx(ba[47:32])) ? sx(ba[15:0]) : sx(ba[47:32]);
      ayhi = (sx(ba[15:0]) < sx(ba[47:32])) ? sx(ba[47:32]) : sx(ba[15:0]);
      axlo = (sx(ba[31:16]) < sx(ba[63:48])) ? sx(ba[31:16]) : sx(ba[63:48]);
      axhi = (sx(ba[31:16]) < sx(ba[63:48])) ? sx(ba[63:48]) : sx(ba[31:16]);
      bylo = (sx(bb[15:0]) < sx(bb[47:32])) ? sx(bb[15:0]) : sx(bb[47:32]);
      byhi = (sx(bb[15:0]) < sx(bb[47:32])) ? sx(bb[47:32]) : sx(bb[15:0]);
      bxlo = (sx(bb[31:16]) < sx(bb[63:48])) ? sx(bb[31:16]) : sx(bb[63:48]);
      bxhi = (sx(bb[31:16]) < sx(bb[63:48])) ? sx(bb[63:48]) : sx(bb[31:16]);
      area_a = longint'(ayhi - aylo) * longint'(axhi - axlo);
      area_b = longint'(byhi - bylo) * longint'(bxhi - bxlo);
      if (area_a == 0 || area_b == 0) return 0;
      iy = ((ayhi < byhi) ? ayhi : byhi) - ((aylo > bylo) ? aylo : bylo);
      ix = ((axhi < bxhi) ? axhi : bxhi) - ((axlo > bxlo) ? axlo : bxlo);
      inter = longint'(iy > 0 ? iy : 0) * longint'(ix > 0 ? ix : 0);
      uni = area_a + area_b - inter;
      return int'((inter << 15) / uni);
   endfunction

   function automatic longint unsigned gauss_weight(int iou, int sigma);
      longint unsigned a, t, n, f, k, r, v;
      a = (longint'(iou) * longint'(iou)) / (longint'(sigma) << 11);
      t = (a * 47274) >> 15;
      n = t >> 12;
      f = t & 4095;
      k = f >> 8;
      r = f & 255;
      v = frac_tab[k] - (((frac_tab[k] - frac_tab[k + 1]) * r) >> 8);
      if (n >= 32) return 0;
      return v >> n;
   endfunction

   function automatic int decayed_score(int s, longint unsigned w);
      longint unsigned mag;
      longint m;
      mag = (s < 0) ? longint'(-s) : longint'(s);
      m = longint'((mag * w) >> 16);
      return (s < 0) ? int'(-m) : int'(m);
   endfunction

   // one accepted box; on the last box of a set, run selection
   task automatic predict_box(logic [15:0] y1, x1, y2, x2, sc, logic last);
      int m, lim, len, start, best, ti, ts, tf, orig, s, iou, i;
      bit hard;
      pick_entry_type e;
      if (n_boxes < MaxBoxes) begin
         box_mem[n_boxes] = {x2, y2, x1, y1};
         if (sx(sc) > cfg_score_thr) begin
            cand_idx[n_cands] = n_boxes;
            cand_scr[n_cands] = sx(sc);
            cand_from[n_cands] = 0;
            n_cands++;
         end
         n_boxes++;
      end
      if (!last) return;
      m = (cfg_max_out < 1) ? 1 : (cfg_max_out > MaxPicked) ? MaxPicked : cfg_max_out;
      lim = (n_cands < m) ? n_cands : m;
      len = 0;
      start = 0;
      while (len < lim && start < n_cands) begin
         best = start;
         for (i = start + 1; i < n_cands; i++)
            if (cand_scr[best] < cand_scr[i]) best = i;
         // best always goes to the front of the pool
         ti = cand_idx[best]; ts = cand_scr[best]; tf = cand_from[best];
         cand_idx[best] = cand_idx[start];
         cand_scr[best] = cand_scr[start];
         cand_from[best] = cand_from[start];
         cand_idx[start] = ti; cand_scr[start] = ts; cand_from[start] = tf;
         orig = ts;
         s = ts;
         hard = 1'b0;
         for (i = len; i > cand_from[start]; i--) begin
            iou = overlap_q15(ti, pick_idx[i - 1]);
            if (iou >= cfg_iou_thr) begin
               hard = 1'b1;
               break;
            end
            if (cfg_sigma != 0) s = decayed_score(s, gauss_weight(iou, cfg_sigma));
            if (s <= cfg_score_thr) break;
         end
         cand_scr[start] = s;
         cand_from[start] = len;
         if (!hard && s == orig) begin
            pick_idx[len] = ti & 10'h3ff;
            pick_scr[len] = s;
            len++;
         end
         // a decayed candidate still above threshold stays in the pool
         if (!hard && s != orig && s > cfg_score_thr) continue;
         start++;
      end
      for (i = 0; i < m; i++) begin
         e.idx = (i < len) ? pick_idx[i][9:0] : 10'd0;
         e.score = (i < len) ? pick_scr[i][15:0] : 16'sd0;
         e.ev = (i < len);
         e.cnt = len[6:0];
         e.le = (i + 1 == m);
         expected_picks.push_back(e);
      end
      n_boxes = 0;
      n_cands = 0;
   endtask

   // ------------------------------------------------------------------
   // box sender: bursts of random length with random gaps
   // ------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_box(logic [15:0] y1, x1, y2, x2, sc, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         // some stretches run back to back
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.corner_y1 <= y1;
      req_bus.corner_x1 <= x1;
      req_bus.corner_y2 <= y2;
      req_bus.corner_x2 <= x2;
      req_bus.box_score <= sc;
      req_bus.last_box  <= last;
      do @(posedge clock); while (!req_bus.ready);
      predict_box(y1, x1, y2, x2, sc, last);
   endtask

   // called in the step of the last acceptance, before time moves on
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_picks.size() != 0) @(posedge clock);
      // let the block settle back into loading
      repeat (16) @(posedge clock);
   endtask

   // leaves valid high; the caller drops it after its last write
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_MAX_OUTPUTS:     cfg_max_out = int'(val[6:0]);
         CSR_IOU_THRESHOLD:   cfg_iou_thr = int'(val);
         CSR_SCORE_FLOOR:     cfg_score_thr = sx(val);
         CSR_SOFT_SIGMA:      cfg_sigma = int'(val);
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [15:0] mo, iou, thr, sig);
      write_reg(CSR_MAX_OUTPUTS, mo);
      write_reg(CSR_IOU_THRESHOLD, iou);
      write_reg(CSR_SCORE_FLOOR, thr);
      write_reg(CSR_SOFT_SIGMA, sig);
      csr_bus.valid <= 1'b0;
   endtask

   // a box near a center, so sets overlap in interesting ways
   task automatic send_near(int cy, int cx, int spread, logic last);
      int y1, x1, h, w;
      logic [15:0] sc;
      y1 = cy + $urandom_range(0, spread) - spread / 2;
      x1 = cx + $urandom_range(0, spread) - spread / 2;
      h = $urandom_range(1, 2 * spread + 1);
      w = $urandom_range(1, 2 * spread + 1);
      sc = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2048) - 512);
      if ($urandom_range(0, 1))
         send_box(16'(y1), 16'(x1), 16'(y1 + h), 16'(x1 + w), sc, last);
      else
         send_box(16'(y1 + h), 16'(x1 + w), 16'(y1), 16'(x1), sc, last);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // defaults after reset: one box alone, extreme corners
      send_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
      drain_results();
      set_regs(16'd4, 16'd16384, 16'h0000, 16'd0);
      // reversed corners, a zero area box, a tie and a score at threshold
      send_box(16'd100, 16'd100, 16'd0, 16'd0, 16'd300, 1'b0);
      send_box(16'd10, 16'd10, 16'd110, 16'd110, 16'd300, 1'b0);
      send_box(16'd5, 16'd5, 16'd5, 16'd50, 16'd400, 1'b0);
      send_box(16'd0, 16'd0, 16'd40, 16'd40, 16'd0, 1'b0);
      send_box(16'd200, 16'd200, 16'd260, 16'd260, 16'hffff, 1'b1);
      drain_results();
      // threshold zero drops anything compared with a pick; clamp of zero
      set_regs(16'd0, 16'd0, 16'h8000, 16'd0);
      send_box(16'd0, 16'd0, 16'd10, 16'd10, 16'd50, 1'b0);
      send_box(16'd500, 16'd500, 16'd510, 16'd510, 16'd60, 1'b1);
      drain_results();
      // threshold above one never suppresses; clamp of 127
      set_regs(16'd127, 16'hffff, 16'h7fff, 16'd0);
      send_box(16'd0, 16'd0, 16'd10, 16'd10, 16'h7fff, 1'b0);
      send_box(16'd0, 16'd0, 16'd10, 16'd10, 16'h7ffe, 1'b1);
      drain_results();
      set_regs(16'd8, 16'd32768, 16'h8000, 16'd0);
      send_box(16'd0, 16'd0, 16'd10, 16'd10, 16'h8001, 1'b0);
      send_box(16'd0, 16'd0, 16'd10, 16'd10, 16'h8001, 1'b1);
      drain_results();
      // soft decay, smallest and largest sigma
      set_regs(16'd6, 16'd30000, 16'hff00, 16'd1);
      send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'd1000, 1'b0);
      send_box(16'd20, 16'd20, 16'd120, 16'd120, 16'd900, 1'b0);
      send_box(16'd50, 16'd50, 16'd150, 16'd150, 16'hfe00, 1'b0);
      send_box(16'd90, 16'd90, 16'd180, 16'd180, 16'd800, 1'b1);
      drain_results();
      set_regs(16'd6, 16'd30000, 16'hff00, 16'hffff);
      send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'd1000, 1'b0);
      send_box(16'd20, 16'd20, 16'd120, 16'd120, 16'd900, 1'b0);
      send_box(16'd50, 16'd50, 16'd150, 16'd150, 16'd700, 1'b1);
      drain_results();
   endtask

   task automatic test_random_sets();
      int sent, n, i, cy, cx, spread, phase;
      sent = 0;
      phase = 0;
      while (sent < 160) begin
         if (phase % 4 == 0) begin
            drain_results();
            set_regs(16'($urandom_range(0, 12) == 0 ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 10)),
                     16'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32768)),
                     16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 512)),
                     16'($urandom_range(0, 1) ? 0 : $urandom_range(0, 3) == 0
                                               ? $urandom : $urandom_range(1, 400)));
         end
         phase++;
         n = $urandom_range(1, 12);
         cy = $urandom_range(0, 4000) - 2000;
         cx = $urandom_range(0, 4000) - 2000;
         spread = $urandom_range(4, 200);
         for (i = 0; i < n; i++) begin
            // mostly clustered boxes, some full range noise
            if ($urandom_range(0, 5) == 0)
               send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), i == n - 1);
            else
               send_near(cy, cx, spread, i == n - 1);
         end
         sent += n;
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // result checker and receiver stalls
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      pick_entry_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_picks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction: idx %0d score %0d",
                        rsp_bus.picked_index, rsp_bus.picked_score);
         end else begin
            e = expected_picks.pop_front();
            if (rsp_bus.picked_index !== e.idx || rsp_bus.picked_score !== e.score ||
                rsp_bus.entry_valid !== e.ev || rsp_bus.picked_count !== e.cnt ||
                rsp_bus.last_entry !== e.le) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp %0d %0d %0b %0d %0b got %0d %0d %0b %0d %0b",
                           e.idx, e.score, e.ev, e.cnt, e.le,
                           rsp_bus.picked_index, rsp_bus.picked_score,
                           rsp_bus.entry_valid, rsp_bus.picked_count,
                           rsp_bus.last_entry);
            end
         end
      end
      // stall pattern with quiet windows
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (cycle_count[9] && $urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 7);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.corner_y1 = '0;
      req_bus.corner_x1 = '0;
      req_bus.corner_y2 = '0;
      req_bus.corner_x2 = '0;
      req_bus.box_score = '0;
      req_bus.last_box = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MAX_OUTPUTS;
      csr_bus.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_sets();
      if (mismatch_count == 0 && expected_picks.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/bnms_pkg.sv
rtl/core/bnms_if.sv
rtl/core/bnms_div.sv
rtl/core/box_non_max_suppression_unit.sv
tb/box_non_max_suppression_unit_tb.sv
